[hw/rtl/assert_macros.svh]
// Assertion macros used by the RTL file that checks itself.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising edge outside reset.
`define FPC_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked at every rising edge, reset included.
`define FPC_CHECK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hw/rtl/fpc_pkg.sv]
package fpc_pkg;

	localparam int COORD_WIDTH = 32;
	localparam int CW = (COORD_WIDTH > 32) ? 32 : ((COORD_WIDTH < 16) ? 16 : COORD_WIDTH);

	localparam int NPLANES = 6;
	localparam int CNT_W   = $clog2(NPLANES);

	localparam int DATA_W  = 32;
	localparam int COEF_W  = DATA_W + 1;
	localparam int MAG_W   = DATA_W + 1;
	localparam int POS_W   = DATA_W + 2;
	localparam int SPLIT   = 17;
	localparam int PPHI_W  = COEF_W + POS_W - SPLIT;
	localparam int PPLO_W  = COEF_W + SPLIT + 1;
	localparam int SUM_W   = 2 * POS_W;
	localparam int FRAC    = 16;

	typedef logic signed [COEF_W-1:0] coef_t;

	typedef struct packed {
		coef_t a;
		coef_t b;
		coef_t c;
		coef_t d;
	} plane_coef_t;

	typedef enum logic [1:0] {
		MODE_LOAD  = 2'd0,
		MODE_POINT = 2'd1,
		MODE_BOX   = 2'd2,
		MODE_CUBE  = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		COEF_A = 2'd0,
		COEF_B = 2'd1,
		COEF_C = 2'd2,
		COEF_D = 2'd3
	} coef_sel_t;

	typedef enum logic [CNT_W-1:0] {
		PL_LEFT   = 3'd0,
		PL_RIGHT  = 3'd1,
		PL_TOP    = 3'd2,
		PL_BOTTOM = 3'd3,
		PL_NEAR   = 3'd4,
		PL_FAR    = 3'd5
	} plane_id_t;

	typedef struct packed {
		logic      load;
		logic      shift;
		coef_sel_t row;
	} cell_ctrl_t;

	typedef struct packed {
		logic [2:0][DATA_W-1:0] ctr;
		logic [2:0][MAG_W-1:0]  mag;
	} item_t;

	typedef struct packed {
		logic valid;
		logic last;
	} feed_t;

	typedef struct packed {
		logic valid;
		logic last;
		logic behind;
	} verdict_t;

	function automatic logic [DATA_W-1:0] sext_coord(input logic [DATA_W-1:0] v);
		return DATA_W'($signed(v[CW-1:0]));
	endfunction

	function automatic logic [MAG_W-1:0] magn(input logic [DATA_W-1:0] v);
		logic signed [MAG_W-1:0] s;
		s = MAG_W'($signed(v));
		return s[MAG_W-1] ? MAG_W'(-s) : MAG_W'(s);
	endfunction

endpackage

[hw/rtl/fpc_cell.sv]
module fpc_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  fpc_pkg::plane_id_t  plane_id,
	input  fpc_pkg::cell_ctrl_t ctrl,
	input  logic [3:0][31:0]    row_elem,
	input  fpc_pkg::plane_coef_t nbr,
	output fpc_pkg::plane_coef_t coef
);
	import fpc_pkg::*;

	plane_coef_t coef_q;
	coef_t       e0, e1, e2, e3, val;

	always_comb begin
		e0 = COEF_W'($signed(sext_coord(row_elem[0])));
		e1 = COEF_W'($signed(sext_coord(row_elem[1])));
		e2 = COEF_W'($signed(sext_coord(row_elem[2])));
		e3 = COEF_W'($signed(sext_coord(row_elem[3])));
		case (plane_id)
			PL_LEFT:   val = e3 + e0;
			PL_RIGHT:  val = e3 - e0;
			PL_TOP:    val = e3 - e1;
			PL_BOTTOM: val = e3 + e1;
			PL_NEAR:   val = e2;
			PL_FAR:    val = e3 - e2;
			default:   val = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q <= '0;
		end else if (ctrl.shift) begin
			coef_q <= nbr;
		end else if (ctrl.load) begin
			case (ctrl.row)
				COEF_A:  coef_q.a <= val;
				COEF_B:  coef_q.b <= val;
				COEF_C:  coef_q.c <= val;
				COEF_D:  coef_q.d <= val;
				default: coef_q.d <= val;
			endcase
		end
	end

	assign coef = coef_q;

endmodule

[hw/rtl/fpc_eval.sv]
module fpc_eval (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  fpc_pkg::feed_t       feed,
	input  fpc_pkg::plane_coef_t plane,
	input  fpc_pkg::item_t       item,
	output fpc_pkg::verdict_t    verdict
);
	import fpc_pkg::*;

	coef_t                     coef_in [3];
	logic signed [POS_W-1:0]   pos_in  [3];

	feed_t                     feed_s1, feed_s2, feed_s3;
	coef_t                     coef_s1 [3];
	coef_t                     d_s1, d_s2;
	logic signed [POS_W-1:0]   pos_s1  [3];
	logic signed [PPHI_W-1:0]  pphi_s2 [3];
	logic signed [PPLO_W-1:0]  pplo_s2 [3];
	logic signed [SUM_W-1:0]   prod_s3 [3];
	logic signed [SUM_W-1:0]   dsh_s3;
	logic signed [SUM_W-1:0]   sum;
	verdict_t                  verdict_s4;

	always_comb begin
		coef_in[0] = plane.a;
		coef_in[1] = plane.b;
		coef_in[2] = plane.c;
		for (int k = 0; k < 3; k++) begin
			if (coef_in[k][COEF_W-1]) begin
				pos_in[k] = POS_W'($signed(item.ctr[k])) - POS_W'(item.mag[k]);
			end else begin
				pos_in[k] = POS_W'($signed(item.ctr[k])) + POS_W'(item.mag[k]);
			end
		end
		sum = prod_s3[0] + prod_s3[1] + prod_s3[2] + dsh_s3;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			feed_s1    <= '0;
			feed_s2    <= '0;
			feed_s3    <= '0;
			verdict_s4 <= '0;
		end else if (en) begin
			feed_s1    <= feed;
			feed_s2    <= feed_s1;
			feed_s3    <= feed_s2;
			verdict_s4 <= '{valid: feed_s3.valid, last: feed_s3.last, behind: sum[SUM_W-1]};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				coef_s1[k] <= coef_in[k];
				pos_s1[k]  <= pos_in[k];
				pphi_s2[k] <= PPHI_W'(coef_s1[k]) *
					PPHI_W'($signed(pos_s1[k][POS_W-1:SPLIT]));
				pplo_s2[k] <= PPLO_W'(coef_s1[k]) *
					PPLO_W'($signed({1'b0, pos_s1[k][SPLIT-1:0]}));
				prod_s3[k] <= (SUM_W'(pphi_s2[k]) <<< SPLIT) + SUM_W'(pplo_s2[k]);
			end
			d_s1   <= plane.d;
			d_s2   <= d_s1;
			dsh_s3 <= SUM_W'(d_s2) <<< FRAC;
		end
	end

	assign verdict = verdict_s4;

endmodule

[hw/rtl/frustum_plane_extract_and_cull_top.sv]
// Load beat: taken when no plane sweep runs and the output is not stalled; gives no result.
// Test beat: the six planes circulate past one evaluator, one plane per cycle while the
// output is not stalled; a new test can be taken while the previous test's last plane is fed.
// Reset (arst_n low, asynchronous) clears all plane coefficients, so every object is visible.
`include "assert_macros.svh"

module frustum_plane_extract_and_cull_top (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         mode,
	input  logic [1:0]         row_index,
	input  logic signed [31:0] elem0,
	input  logic signed [31:0] elem1,
	input  logic signed [31:0] elem2,
	input  logic signed [31:0] elem3,
	input  logic signed [31:0] half_x,
	input  logic signed [31:0] half_y,
	input  logic signed [31:0] half_z,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               visible
);
	import fpc_pkg::*;

	plane_coef_t      coef_ring [NPLANES];
	cell_ctrl_t       cell_ctrl;
	logic [3:0][31:0] row_elem;
	item_t            item_d, item_q;
	feed_t            feed;
	verdict_t         res;

	logic             en, acc, feed_last, is_load;
	logic             feed_active_q;
	logic [CNT_W-1:0] cnt_q;
	logic             rej_q;
	logic             out_valid_q, visible_q;

	assign en        = !out_valid_q || out_ready;
	assign is_load   = (mode_t'(mode) == MODE_LOAD);
	assign feed_last = (cnt_q == CNT_W'(NPLANES - 1));
	assign in_ready  = en && (!feed_active_q || (feed_last && !is_load));
	assign acc       = in_valid && in_ready;

	assign row_elem        = {elem3, elem2, elem1, elem0};
	assign cell_ctrl.load  = acc && is_load;
	assign cell_ctrl.shift = en && feed_active_q;
	assign cell_ctrl.row   = coef_sel_t'(row_index);

	for (genvar i = 0; i < NPLANES; i++) begin : g_cell
		fpc_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.plane_id (plane_id_t'(CNT_W'(i))),
			.ctrl     (cell_ctrl),
			.row_elem (row_elem),
			.nbr      (coef_ring[(i + 1) % NPLANES]),
			.coef     (coef_ring[i])
		);
	end

	always_comb begin
		item_d.ctr[0] = sext_coord(elem0);
		item_d.ctr[1] = sext_coord(elem1);
		item_d.ctr[2] = sext_coord(elem2);
		case (mode_t'(mode))
			MODE_BOX: begin
				item_d.mag[0] = magn(sext_coord(half_x));
				item_d.mag[1] = magn(sext_coord(half_y));
				item_d.mag[2] = magn(sext_coord(half_z));
			end
			MODE_CUBE: begin
				item_d.mag[0] = magn(sext_coord(elem3));
				item_d.mag[1] = magn(sext_coord(elem3));
				item_d.mag[2] = magn(sext_coord(elem3));
			end
			default: begin
				item_d.mag = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (acc && !is_load) begin
			item_q <= item_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			feed_active_q <= 1'b0;
			cnt_q         <= '0;
		end else if (acc && !is_load) begin
			feed_active_q <= 1'b1;
			cnt_q         <= '0;
		end else if (en && feed_active_q) begin
			cnt_q <= cnt_q + CNT_W'(1);
			if (feed_last) begin
				feed_active_q <= 1'b0;
			end
		end
	end

	assign feed.valid = feed_active_q;
	assign feed.last  = feed_last;

	fpc_eval u_eval (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.feed    (feed),
		.plane   (coef_ring[0]),
		.item    (item_q),
		.verdict (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rej_q       <= 1'b0;
			out_valid_q <= 1'b0;
			visible_q   <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (en && res.valid) begin
				if (res.last) begin
					out_valid_q <= 1'b1;
					visible_q   <= !(rej_q || res.behind);
					rej_q       <= 1'b0;
				end else begin
					rej_q <= rej_q || res.behind;
				end
			end
		end
	end

	assign out_valid = out_valid_q;
	assign visible   = visible_q;

	`FPC_ASSERT(a_cnt_bound, feed_active_q |-> (cnt_q <= CNT_W'(NPLANES - 1)), "plane counter beyond the last plane")
	`FPC_ASSERT(a_out_from_last, $rose(out_valid_q) |-> $past(res.valid && res.last), "result beat without a final plane verdict")
	`FPC_CHECK(a_reset_quiet, !arst_n |-> (!out_valid_q && !feed_active_q), "activity during reset")

endmodule

[dv/tb_frustum_plane_extract_and_cull_top.sv]
`timescale 1ns / 100ps

module tb_frustum_plane_extract_and_cull_top;
	import fpc_pkg::*;

	localparam int          ONE          = 65536;
	localparam int          IDLE_LIMIT   = 3000;
	localparam int          DRAIN_CYCLES = 20;
	localparam logic [31:0] C_MIN        = 32'h8000_0000;
	localparam logic [31:0] C_MAX        = 32'h7fff_ffff;

	typedef struct packed {
		mode_t            mode;
		logic [1:0]       row;
		logic [3:0][31:0] e;
		logic [2:0][31:0] h;
	} cull_beat_t;

	logic               clk       = 1'b0;
	logic               arst_n    = 1'b1;
	logic               in_valid  = 1'b0;
	logic               in_ready;
	logic [1:0]         mode      = 2'd0;
	logic [1:0]         row_index = 2'd0;
	logic signed [31:0] elem0     = '0;
	logic signed [31:0] elem1     = '0;
	logic signed [31:0] elem2     = '0;
	logic signed [31:0] elem3     = '0;
	logic signed [31:0] half_x    = '0;
	logic signed [31:0] half_y    = '0;
	logic signed [31:0] half_z    = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic               visible;

	longint plane_coef[24];
	bit     visible_q[$];
	bit     vis_exp;
	bit     no_idle;
	int     hold_len;
	int     stall_left;
	int     idle_cycles;
	int     n_errors;
	int     n_loads;
	int     n_tests;
	int     n_checked;
	int     n_seen_visible;

	frustum_plane_extract_and_cull_top i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.mode      (mode),
		.row_index (row_index),
		.elem0     (elem0),
		.elem1     (elem1),
		.elem2     (elem2),
		.elem3     (elem3),
		.half_x    (half_x),
		.half_y    (half_y),
		.half_z    (half_z),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.visible   (visible)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic longint to_coord(input logic [31:0] v);
		longint x;
		x = longint'($signed(v));
		return (x <<< (64 - CW)) >>> (64 - CW);
	endfunction

	function automatic int rand_fix(input int span);
		return int'($urandom_range(0, 2 * span)) - span;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic void apply_row(input cull_beat_t b);
		longint e0, e1, e2, e3;
		int r;
		e0 = to_coord(b.e[0]);
		e1 = to_coord(b.e[1]);
		e2 = to_coord(b.e[2]);
		e3 = to_coord(b.e[3]);
		r  = int'(b.row);
		plane_coef[int'(PL_LEFT) * 4 + r]   = e3 + e0;
		plane_coef[int'(PL_RIGHT) * 4 + r]  = e3 - e0;
		plane_coef[int'(PL_TOP) * 4 + r]    = e3 - e1;
		plane_coef[int'(PL_BOTTOM) * 4 + r] = e3 + e1;
		plane_coef[int'(PL_NEAR) * 4 + r]   = e2;
		plane_coef[int'(PL_FAR) * 4 + r]    = e3 - e2;
	endfunction

	// Each plane is tested at the corner furthest along its normal, exactly in 128 bits.
	function automatic bit predict_visible(input cull_beat_t b);
		longint ctr[3];
		longint ext[3];
		logic signed [127:0] plane_dist, coef, pos;
		int p, k;
		for (k = 0; k < 3; k++) begin
			ctr[k] = to_coord(b.e[k]);
			case (b.mode)
				MODE_BOX:  ext[k] = to_coord(b.h[k]);
				MODE_CUBE: ext[k] = to_coord(b.e[3]);
				default:   ext[k] = 0;
			endcase
			if (ext[k] < 0)
				ext[k] = -ext[k];
		end
		for (p = 0; p < NPLANES; p++) begin
			plane_dist = 0;
			for (k = 0; k < 3; k++) begin
				coef = plane_coef[p * 4 + int'(COEF_A) + k];
				pos  = (coef >= 0) ? ctr[k] + ext[k] : ctr[k] - ext[k];
				plane_dist = plane_dist + coef * pos;
			end
			coef = plane_coef[p * 4 + int'(COEF_D)];
			plane_dist = plane_dist + coef * ONE;
			if (plane_dist < 0)
				return 1'b0;
		end
		return 1'b1;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("mismatch at %0t ns: %s", $time, msg);
		n_errors++;
	endtask

	task automatic send_beat(input cull_beat_t b);
		int gap;
		gap = no_idle ? 0 : pick_gap();
		if (gap != 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid  <= 1'b1;
		mode      <= b.mode;
		row_index <= b.row;
		elem0     <= b.e[0];
		elem1     <= b.e[1];
		elem2     <= b.e[2];
		elem3     <= b.e[3];
		half_x    <= b.h[0];
		half_y    <= b.h[1];
		half_z    <= b.h[2];
		do
			@(posedge clk);
		while (!in_ready);
		if (b.mode == MODE_LOAD) begin
			apply_row(b);
			n_loads++;
		end else begin
			visible_q.push_back(predict_visible(b));
			n_tests++;
		end
	endtask

	task automatic send_fields(input mode_t m, input logic [1:0] r,
			input logic [31:0] e0, input logic [31:0] e1, input logic [31:0] e2,
			input logic [31:0] e3, input logic [31:0] hx, input logic [31:0] hy,
			input logic [31:0] hz);
		cull_beat_t b;
		b.mode = m;
		b.row  = r;
		b.e    = {e3, e2, e1, e0};
		b.h    = {hz, hy, hx};
		send_beat(b);
	endtask

	task automatic send_wild_load();
		send_fields(MODE_LOAD, 2'($urandom_range(0, 3)), $urandom, $urandom, $urandom,
			$urandom, $urandom, $urandom, $urandom);
	endtask

	task automatic send_test(input bit wild);
		mode_t m;
		logic [31:0] e3, hx, hy, hz;
		m = mode_t'($urandom_range(1, 3));
		if (wild) begin
			send_fields(m, 2'($urandom), $urandom, $urandom, $urandom, $urandom,
				$urandom, $urandom, $urandom);
		end else begin
			e3 = (m == MODE_CUBE) ? rand_fix(ONE) : $urandom;
			hx = (m == MODE_BOX) ? rand_fix(ONE) : $urandom;
			hy = (m == MODE_BOX) ? rand_fix(ONE) : $urandom;
			hz = (m == MODE_BOX) ? rand_fix(ONE) : $urandom;
			send_fields(m, 2'($urandom), rand_fix(3 * ONE), rand_fix(3 * ONE),
				rand_fix(3 * ONE), e3, hx, hy, hz);
		end
	endtask

	// A scaled and slightly skewed box volume, so that visibility is well mixed.
	task automatic load_view_matrix();
		logic [3:0][31:0] m[4];
		int r, c, s, sel;
		bit reverse;
		for (r = 0; r < 3; r++) begin
			for (c = 0; c < 4; c++) begin
				if (r == c) begin
					s = $urandom_range(ONE / 4, 2 * ONE);
					m[r][c] = ($urandom_range(0, 7) == 0) ? -s : s;
				end else begin
					m[r][c] = $urandom_range(0, 1) ? rand_fix(ONE / 8) : 0;
				end
			end
		end
		m[3] = {32'(ONE), 32'(rand_fix(ONE / 2)), 32'(rand_fix(ONE / 2)),
			32'(rand_fix(ONE / 2))};
		reverse = $urandom_range(0, 1);
		for (r = 0; r < 4; r++) begin
			sel = reverse ? 3 - r : r;
			send_fields(MODE_LOAD, 2'(sel), m[sel][0], m[sel][1], m[sel][2], m[sel][3],
				$urandom, $urandom, $urandom);
		end
	endtask

	task automatic test_reset_planes();
		send_fields(MODE_POINT, 2'd0, C_MAX, C_MIN, C_MAX, 0, 0, 0, 0);
		send_fields(MODE_CUBE, 2'd3, C_MIN, C_MIN, C_MIN, C_MIN, 0, 0, 0);
	endtask

	task automatic test_clip_boundaries();
		send_fields(MODE_LOAD, COEF_A, ONE, 0, 0, 0, 0, 0, 0);
		send_fields(MODE_LOAD, COEF_B, 0, ONE, 0, 0, 0, 0, 0);
		send_fields(MODE_LOAD, COEF_C, 0, 0, ONE, 0, 0, 0, 0);
		send_fields(MODE_LOAD, COEF_D, 0, 0, 0, ONE, 0, 0, 0);
		send_fields(MODE_POINT, 2'd0, 0, 0, 0, 0, 0, 0, 0);
		send_fields(MODE_POINT, 2'd0, -ONE, 0, 0, 0, 0, 0, 0);
		send_fields(MODE_POINT, 2'd0, -ONE - 1, 0, 0, 0, 0, 0, 0);
		send_fields(MODE_POINT, 2'd0, 0, 0, -1, 0, 0, 0, 0);
		send_fields(MODE_POINT, 2'd0, 0, ONE + 1, ONE / 2, 0, 0, 0, 0);
		send_fields(MODE_BOX, 2'd0, -3 * ONE, 0, ONE / 2, 0, 5 * ONE / 2, 0, 0);
		send_fields(MODE_BOX, 2'd0, -3 * ONE, 0, ONE / 2, 0, -5 * ONE / 2, 0, 0);
		send_fields(MODE_BOX, 2'd0, -3 * ONE, 0, ONE / 2, 0, 3 * ONE / 2, 0, 0);
		send_fields(MODE_CUBE, 2'd0, 0, 0, -2 * ONE, ONE, 0, 0, 0);
		send_fields(MODE_CUBE, 2'd0, 0, 0, -2 * ONE, -3 * ONE, 0, 0, 0);
	endtask

	task automatic test_degenerate_and_extremes();
		send_fields(MODE_LOAD, COEF_A, 0, 0, 0, 0, 0, 0, 0);
		send_fields(MODE_LOAD, COEF_B, 0, 0, 0, 0, 0, 0, 0);
		send_fields(MODE_LOAD, COEF_C, 0, 0, 0, 0, 0, 0, 0);
		send_fields(MODE_LOAD, COEF_D, 0, 0, 0, ONE, 0, 0, 0);
		send_fields(MODE_POINT, 2'd0, C_MIN, C_MAX, C_MIN, 0, 0, 0, 0);
		send_fields(MODE_LOAD, COEF_D, 0, 0, 2 * ONE, ONE, 0, 0, 0);
		send_fields(MODE_POINT, 2'd0, 0, 0, 0, 0, 0, 0, 0);
		send_fields(MODE_LOAD, COEF_A, C_MIN, C_MAX, C_MIN, C_MAX, 0, 0, 0);
		send_fields(MODE_LOAD, COEF_D, C_MAX, C_MIN, C_MAX, C_MIN, 0, 0, 0);
		send_fields(MODE_POINT, 2'd0, C_MAX, C_MIN, C_MAX, 0, 0, 0, 0);
		send_fields(MODE_BOX, 2'd0, 0, 0, 0, 0, C_MIN, C_MIN, C_MIN);
	endtask

	// The receiver holds off while tests keep arriving, so the block must stall its input.
	task automatic test_backpressure();
		load_view_matrix();
		no_idle  = 1'b1;
		hold_len = 160;
		repeat (30) send_test(1'b0);
		no_idle = 1'b0;
	endtask

	task automatic test_random_scenes();
		int round, pick;
		for (round = 0; round < 21; round++) begin
			no_idle = ($urandom_range(0, 5) == 0);
			if ($urandom_range(0, 4) != 0)
				load_view_matrix();
			else
				repeat ($urandom_range(1, 4)) send_wild_load();
			repeat ($urandom_range(10, 20)) begin
				pick = $urandom_range(0, 19);
				if (pick == 0)
					send_wild_load();
				else
					send_test(pick < 3);
			end
		end
		no_idle = 1'b0;
	endtask

	always begin
		@(negedge clk);
		if (hold_len != 0) begin
			out_ready <= 1'b0;
			repeat (hold_len) @(negedge clk);
			hold_len = 0;
		end else if (no_idle) begin
			out_ready <= 1'b1;
		end else if (stall_left != 0) begin
			out_ready <= 1'b0;
			stall_left--;
		end else if ($urandom_range(0, 7) == 0) begin
			out_ready  <= 1'b0;
			stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) :
				$urandom_range(0, 2);
		end else begin
			out_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (visible_q.size() == 0) begin
				report_mismatch($sformatf("visible=%0b with no test pending", visible));
			end else begin
				vis_exp = visible_q.pop_front();
				n_checked++;
				if (visible === 1'b1)
					n_seen_visible++;
				if (visible !== vis_exp)
					report_mismatch($sformatf("visible=%0b, expected %0b", visible, vis_exp));
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready)) begin
				idle_cycles <= 0;
			end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
				$display("timeout after %0d cycles without a beat", IDLE_LIMIT);
				$display("status: fail");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	initial begin
		arst_n <= 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_reset_planes();
		test_clip_boundaries();
		test_degenerate_and_extremes();
		test_backpressure();
		test_random_scenes();
		@(negedge clk);
		in_valid <= 1'b0;
		while (visible_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("%0d row loads and %0d object tests sent, %0d verdicts checked (%0d visible),",
			n_loads, n_tests, n_checked, n_seen_visible);
		$display("covering boundaries, degenerate planes, extreme values and a long output stall.");
		if (n_errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
